@@ rtl/tip_pkg.sv @@
`default_nettype none

package tip_pkg;

    localparam int NUM_TASKS  = 16;
    localparam int TIME_BITS  = 48;
    localparam int FIELD_W    = 48;
    localparam int ID_W       = 4;
    localparam int CNT_W      = 32;
    localparam int TASK_IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [FIELD_W-1:0]    field_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [ID_W-1:0]       id_t;
    typedef logic [TASK_IDX_W-1:0] idx_t;

    localparam time_t TIME_MAX = {TIME_BITS{1'b1}};
    localparam cnt_t  CNT_MAX  = {CNT_W{1'b1}};

    typedef enum logic {
        OP_PASS  = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } tip_cmd_t;

endpackage

`default_nettype wire

@@ rtl/tip_req_if.sv @@
`default_nettype none

interface tip_req_if;
    import tip_pkg::*;

    logic   valid;
    logic   ready;
    logic   opcode;
    id_t    task_id;
    field_t spacing_us;
    field_t loop_start_us;
    field_t start_us;
    field_t stop_us;

    modport source (
        output valid, opcode, task_id, spacing_us, loop_start_us, start_us, stop_us,
        input  ready
    );

    modport sink (
        input  valid, opcode, task_id, spacing_us, loop_start_us, start_us, stop_us,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/tip_rsp_if.sv @@
`default_nettype none

interface tip_rsp_if;
    import tip_pkg::*;

    logic   valid;
    logic   ready;
    logic   was_due;
    logic   timing_ok;
    cnt_t   start_total;
    field_t run_sum;
    field_t run_least;
    field_t run_most;
    field_t period_least;
    field_t period_most;

    modport source (
        output valid, was_due, timing_ok, start_total, run_sum, run_least, run_most,
               period_least, period_most,
        input  ready
    );

    modport sink (
        input  valid, was_due, timing_ok, start_total, run_sum, run_least, run_most,
               period_least, period_most,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/tip_ctrl.sv @@
`default_nettype none

module tip_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output tip_pkg::tip_cmd_t     cmd
);
    import tip_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_CALC:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ rtl/tip_datapath.sv @@
`default_nettype none

module tip_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tip_pkg::tip_cmd_t cmd,
    input  wire logic              opcode,
    input  wire tip_pkg::id_t      task_id,
    input  wire tip_pkg::field_t   spacing_us,
    input  wire tip_pkg::field_t   loop_start_us,
    input  wire tip_pkg::field_t   start_us,
    input  wire tip_pkg::field_t   stop_us,
    output logic                   was_due,
    output logic                   timing_ok,
    output tip_pkg::cnt_t          start_total,
    output tip_pkg::field_t        run_sum,
    output tip_pkg::field_t        run_least,
    output tip_pkg::field_t        run_most,
    output tip_pkg::field_t        period_least,
    output tip_pkg::field_t        period_most
);
    import tip_pkg::*;

    // entry storage
    cnt_t  starts_mem      [NUM_TASKS];
    time_t run_accum_mem   [NUM_TASKS];
    time_t run_low_mem     [NUM_TASKS];
    time_t run_high_mem    [NUM_TASKS];
    time_t period_low_mem  [NUM_TASKS];
    time_t period_high_mem [NUM_TASKS];
    time_t last_start_mem  [NUM_TASKS];
    time_t next_due_mem    [NUM_TASKS];
    logic [NUM_TASKS-1:0] stats_vld_reg;
    logic [NUM_TASKS-1:0] seen_reg;

    // capture side
    idx_t   rd_idx;
    logic   rd_in_range;
    logic   rd_sv;
    logic   rd_sn;
    time_t  in_interval;
    time_t  in_loop;
    time_t  in_t0;
    time_t  in_t1;
    logic [TIME_BITS:0] due_sum;
    logic [TIME_BITS:0] run_diff;

    // registered item and entry
    logic  op_reg;
    logic  in_range_reg;
    logic  ok_reg;
    logic  seen_e_reg;
    idx_t  idx_reg;
    time_t t0_reg;
    time_t loop_reg;
    time_t nd_reg;
    time_t run_reg;
    time_t e_last_reg;
    time_t e_due_reg;
    cnt_t  e_starts_reg;
    time_t e_accum_reg;
    time_t e_rlow_reg;
    time_t e_rhigh_reg;
    time_t e_plow_reg;
    time_t e_phigh_reg;

    // update side
    logic  due_now;
    logic [TIME_BITS:0] period_diff;
    time_t period_val;
    cnt_t  new_starts;
    logic [TIME_BITS:0] accum_sum;
    time_t new_accum;
    time_t new_rlow;
    time_t new_rhigh;
    time_t new_plow;
    time_t new_phigh;

    // result register
    logic  was_due_reg;
    logic  timing_ok_reg;
    cnt_t  start_total_reg;
    time_t run_sum_reg;
    time_t run_least_reg;
    time_t run_most_reg;
    time_t period_least_reg;
    time_t period_most_reg;

    assign rd_idx      = idx_t'(task_id);
    assign rd_in_range = 32'(task_id) < 32'(NUM_TASKS);
    assign rd_sv       = stats_vld_reg[rd_idx];
    assign rd_sn       = seen_reg[rd_idx];
    assign in_interval = time_t'(spacing_us);
    assign in_loop     = time_t'(loop_start_us);
    assign in_t0       = time_t'(start_us);
    assign in_t1       = time_t'(stop_us);
    assign due_sum     = {1'b0, in_loop} + {1'b0, in_interval};
    assign run_diff    = {1'b0, in_t1} - {1'b0, in_t0};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= opcode;
            in_range_reg <= rd_in_range;
            ok_reg       <= !run_diff[TIME_BITS] && (run_diff[TIME_BITS-1:0] != '0);
            seen_e_reg   <= rd_sn;
            idx_reg      <= rd_idx;
            t0_reg       <= in_t0;
            loop_reg     <= in_loop;
            nd_reg       <= due_sum[TIME_BITS] ? TIME_MAX : due_sum[TIME_BITS-1:0];
            run_reg      <= run_diff[TIME_BITS] ? '0 : run_diff[TIME_BITS-1:0];
            e_last_reg   <= rd_sn ? last_start_mem[rd_idx] : '0;
            e_due_reg    <= rd_sn ? next_due_mem[rd_idx] : '0;
            e_starts_reg <= rd_sv ? starts_mem[rd_idx] : '0;
            e_accum_reg  <= rd_sv ? run_accum_mem[rd_idx] : '0;
            e_rlow_reg   <= rd_sv ? run_low_mem[rd_idx] : TIME_MAX;
            e_rhigh_reg  <= rd_sv ? run_high_mem[rd_idx] : '0;
            e_plow_reg   <= rd_sv ? period_low_mem[rd_idx] : TIME_MAX;
            e_phigh_reg  <= rd_sv ? period_high_mem[rd_idx] : '0;
        end
    end

    assign due_now     = (op_t'(op_reg) == OP_PASS) && in_range_reg && (e_due_reg < loop_reg);
    assign period_diff = {1'b0, t0_reg} - {1'b0, e_last_reg};
    assign period_val  = period_diff[TIME_BITS] ? '0 : period_diff[TIME_BITS-1:0];

    assign new_starts = (e_starts_reg == CNT_MAX) ? e_starts_reg : e_starts_reg + 1'b1;
    assign accum_sum  = {1'b0, e_accum_reg} + {1'b0, run_reg};
    assign new_accum  = accum_sum[TIME_BITS] ? TIME_MAX : accum_sum[TIME_BITS-1:0];
    assign new_rlow   = (run_reg < e_rlow_reg) ? run_reg : e_rlow_reg;
    assign new_rhigh  = (run_reg > e_rhigh_reg) ? run_reg : e_rhigh_reg;
    assign new_plow   = (seen_e_reg && (period_val < e_plow_reg)) ? period_val : e_plow_reg;
    assign new_phigh  = (seen_e_reg && (period_val > e_phigh_reg)) ? period_val : e_phigh_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit && due_now)
        begin
            starts_mem[idx_reg]      <= new_starts;
            run_accum_mem[idx_reg]   <= new_accum;
            run_low_mem[idx_reg]     <= new_rlow;
            run_high_mem[idx_reg]    <= new_rhigh;
            period_low_mem[idx_reg]  <= new_plow;
            period_high_mem[idx_reg] <= new_phigh;
            last_start_mem[idx_reg]  <= t0_reg;
            next_due_mem[idx_reg]    <= nd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_vld_reg <= '0;
            seen_reg      <= '0;
        end
        else if (cmd.commit)
        begin
            if (op_t'(op_reg) == OP_CLEAR)
            begin
                stats_vld_reg <= '0;
            end
            else if (due_now)
            begin
                stats_vld_reg[idx_reg] <= 1'b1;
                seen_reg[idx_reg]      <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            priority if (!in_range_reg)
            begin
                was_due_reg      <= 1'b0;
                timing_ok_reg    <= 1'b0;
                start_total_reg  <= '0;
                run_sum_reg      <= '0;
                run_least_reg    <= '0;
                run_most_reg     <= '0;
                period_least_reg <= '0;
                period_most_reg  <= '0;
            end
            else if (op_t'(op_reg) == OP_CLEAR)
            begin
                was_due_reg      <= 1'b0;
                timing_ok_reg    <= 1'b0;
                start_total_reg  <= '0;
                run_sum_reg      <= '0;
                run_least_reg    <= TIME_MAX;
                run_most_reg     <= '0;
                period_least_reg <= TIME_MAX;
                period_most_reg  <= '0;
            end
            else if (due_now)
            begin
                was_due_reg      <= 1'b1;
                timing_ok_reg    <= ok_reg;
                start_total_reg  <= new_starts;
                run_sum_reg      <= new_accum;
                run_least_reg    <= new_rlow;
                run_most_reg     <= new_rhigh;
                period_least_reg <= new_plow;
                period_most_reg  <= new_phigh;
            end
            else
            begin
                was_due_reg      <= 1'b0;
                timing_ok_reg    <= 1'b0;
                start_total_reg  <= e_starts_reg;
                run_sum_reg      <= e_accum_reg;
                run_least_reg    <= e_rlow_reg;
                run_most_reg     <= e_rhigh_reg;
                period_least_reg <= e_plow_reg;
                period_most_reg  <= e_phigh_reg;
            end
        end
    end

    assign was_due      = was_due_reg;
    assign timing_ok    = timing_ok_reg;
    assign start_total  = start_total_reg;
    assign run_sum      = FIELD_W'(run_sum_reg);
    assign run_least    = FIELD_W'(run_least_reg);
    assign run_most     = FIELD_W'(run_most_reg);
    assign period_least = FIELD_W'(period_least_reg);
    assign period_most  = FIELD_W'(period_most_reg);

endmodule

`default_nettype wire

@@ rtl/task_interval_profiler_top.sv @@
// the table entry is read when a request beat is taken; the update and the result beat
// are registered together once the result slot is free, and only then is a new request taken
// a stalled result holds the next item in its update cycle; the request after it waits
// reset: asynchronous, active low; all table entries return to their reset values
// at once through per-entry valid flags, no clearing pass
`default_nettype none

module task_interval_profiler_top (
    input  wire logic clk,
    input  wire logic rst_n,
    tip_req_if.sink   req,
    tip_rsp_if.source rsp
);
    import tip_pkg::*;

    tip_cmd_t cmd;

    tip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    tip_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .opcode        (req.opcode),
        .task_id       (req.task_id),
        .spacing_us    (req.spacing_us),
        .loop_start_us (req.loop_start_us),
        .start_us      (req.start_us),
        .stop_us       (req.stop_us),
        .was_due       (rsp.was_due),
        .timing_ok     (rsp.timing_ok),
        .start_total   (rsp.start_total),
        .run_sum       (rsp.run_sum),
        .run_least     (rsp.run_least),
        .run_most      (rsp.run_most),
        .period_least  (rsp.period_least),
        .period_most   (rsp.period_most)
    );

endmodule

`default_nettype wire

@@ rtl/tip_checker.sv @@
`default_nettype none

module tip_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            req_valid,
    input wire logic            req_ready,
    input wire logic            rsp_valid,
    input wire logic            rsp_ready,
    input wire logic            was_due,
    input wire logic            timing_ok,
    input wire tip_pkg::cnt_t   start_total,
    input wire tip_pkg::field_t run_sum
);
    import tip_pkg::*;

    // one item in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while an item is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && timing_ok |-> was_due)
    else $error("timing_ok without was_due");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && was_due |-> start_total != '0)
    else $error("due task reports zero starts");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(start_total) && $stable(run_sum))
    else $error("result beat changed while stalled");

endmodule

bind task_interval_profiler_top tip_checker u_tip_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .was_due     (rsp.was_due),
    .timing_ok   (rsp.timing_ok),
    .start_total (rsp.start_total),
    .run_sum     (rsp.run_sum)
);

`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tip_pkg::*;

    localparam int RANDOM_PASSES = 900;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 80;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        op_t   op;
        id_t   id;
        time_t interval;
        time_t loop_t;
        time_t t_start;
        time_t t_stop;
    } sched_item_t;

    typedef struct packed {
        logic   was_due;
        logic   timing_ok;
        cnt_t   start_total;
        field_t run_sum;
        field_t run_least;
        field_t run_most;
        field_t period_least;
        field_t period_most;
    } task_stats_t;

    logic clk;
    logic rst_n;

    tip_req_if req ();
    tip_rsp_if rsp ();

    task_interval_profiler_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    sched_item_t sched_q[$];
    task_stats_t stats_q[$];

    cnt_t  tbl_starts [NUM_TASKS];
    time_t tbl_run_sum[NUM_TASKS];
    time_t tbl_run_lo [NUM_TASKS];
    time_t tbl_run_hi [NUM_TASKS];
    time_t tbl_per_lo [NUM_TASKS];
    time_t tbl_per_hi [NUM_TASKS];
    time_t tbl_last   [NUM_TASKS];
    time_t tbl_due    [NUM_TASKS];
    bit    tbl_seen   [NUM_TASKS];

    time_t gen_due [NUM_TASKS];
    time_t gen_last[NUM_TASKS];

    bit req_fired;
    bit rsp_fired;
    int req_count;
    int mismatches;
    int idle_cycles;
    int send_gap;
    int recv_wait;
    int hold_left;
    bit hold_done;

    function automatic time_t sat_sum(time_t a, time_t b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
    endfunction

    function automatic time_t rand_time();
        return time_t'({$urandom(), $urandom()});
    endfunction

    function automatic task_stats_t update_task_stats(sched_item_t it);
        task_stats_t r;
        time_t       per;
        time_t       run;
        int          k;
        r = '0;
        if (it.op == OP_CLEAR) begin
            for (k = 0; k < NUM_TASKS; k++) begin
                tbl_starts[k]  = '0;
                tbl_run_sum[k] = '0;
                tbl_run_lo[k]  = TIME_MAX;
                tbl_run_hi[k]  = '0;
                tbl_per_lo[k]  = TIME_MAX;
                tbl_per_hi[k]  = '0;
            end
        end
        if (int'(it.id) >= NUM_TASKS)
            return r;
        if (it.op == OP_PASS && tbl_due[it.id] < it.loop_t) begin
            r.was_due = 1'b1;
            tbl_due[it.id] = sat_sum(it.loop_t, it.interval);
            if (tbl_starts[it.id] != CNT_MAX)
                tbl_starts[it.id] = tbl_starts[it.id] + 1'b1;
            per = (tbl_last[it.id] < it.t_start) ? it.t_start - tbl_last[it.id] : '0;
            tbl_last[it.id] = it.t_start;
            if (tbl_seen[it.id]) begin
                if (per > tbl_per_hi[it.id])
                    tbl_per_hi[it.id] = per;
                if (per < tbl_per_lo[it.id])
                    tbl_per_lo[it.id] = per;
            end
            tbl_seen[it.id] = 1'b1;
            if (it.t_start < it.t_stop) begin
                run = it.t_stop - it.t_start;
                r.timing_ok = 1'b1;
            end
            else begin
                run = '0;
            end
            tbl_run_sum[it.id] = sat_sum(tbl_run_sum[it.id], run);
            if (run < tbl_run_lo[it.id])
                tbl_run_lo[it.id] = run;
            if (run > tbl_run_hi[it.id])
                tbl_run_hi[it.id] = run;
        end
        r.start_total  = tbl_starts[it.id];
        r.run_sum      = tbl_run_sum[it.id];
        r.run_least    = tbl_run_lo[it.id];
        r.run_most     = tbl_run_hi[it.id];
        r.period_least = tbl_per_lo[it.id];
        r.period_most  = tbl_per_hi[it.id];
        return r;
    endfunction

    function automatic void queue_item(op_t op, id_t id, time_t iv, time_t lp,
                                       time_t t0, time_t t1);
        sched_item_t it;
        it = '{op, id, iv, lp, t0, t1};
        sched_q.push_back(it);
        if (op == OP_PASS && gen_due[id] < lp) begin
            gen_due[id]  = sat_sum(lp, iv);
            gen_last[id] = t0;
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
        if (a !== e) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch in %s: expected %h, actual %h", name, e, a);
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // request side driver
    always @(negedge clk)
    begin
        sched_item_t it;
        logic        nv;
        if (!rst_n) begin
            req.valid <= 1'b0;
        end
        else begin
            nv = req.valid && !req_fired;
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end
                else if (sched_q.size() > 0) begin
                    it = sched_q.pop_front();
                    req.opcode        <= it.op;
                    req.task_id       <= it.id;
                    req.spacing_us    <= it.interval;
                    req.loop_start_us <= it.loop_t;
                    req.start_us      <= it.t_start;
                    req.stop_us       <= it.t_stop;
                    nv = 1'b1;
                    send_gap = (((req_count / 120) % 3) == 1) ? 0 : $urandom_range(0, 4);
                end
            end
            req.valid <= nv;
        end
    end

    // result side ready, with one long hold-off to back up the input
    always @(negedge clk)
    begin
        logic nr;
        if (!rst_n) begin
            rsp.ready <= 1'b0;
        end
        else begin
            if (rsp_fired)
                recv_wait = (((req_count / 120) % 3) == 1) ? 0 : $urandom_range(0, 4);
            if (!hold_done && req_count >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                nr = 1'b0;
            end
            else if (recv_wait > 0) begin
                recv_wait--;
                nr = 1'b0;
            end
            else begin
                nr = 1'b1;
            end
            rsp.ready <= nr;
        end
    end

    // beat monitor, checker and watchdog
    always @(posedge clk)
    begin
        sched_item_t it;
        task_stats_t e;
        req_fired = rst_n && req.valid && req.ready;
        rsp_fired = rst_n && rsp.valid && rsp.ready;
        if (rsp_fired) begin
            if (stats_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result beat with nothing expected");
            end
            else begin
                e = stats_q.pop_front();
                check_field("was_due", e.was_due, rsp.was_due);
                check_field("timing_ok", e.timing_ok, rsp.timing_ok);
                check_field("start_total", e.start_total, rsp.start_total);
                check_field("run_sum", e.run_sum, rsp.run_sum);
                check_field("run_least", e.run_least, rsp.run_least);
                check_field("run_most", e.run_most, rsp.run_most);
                check_field("period_least", e.period_least, rsp.period_least);
                check_field("period_most", e.period_most, rsp.period_most);
            end
        end
        if (req_fired) begin
            it.op       = op_t'(req.opcode);
            it.id       = req.task_id;
            it.interval = req.spacing_us;
            it.loop_t   = req.loop_start_us;
            it.t_start  = req.start_us;
            it.t_stop   = req.stop_us;
            stats_q.push_back(update_task_stats(it));
            req_count++;
        end
        if (req_fired || rsp_fired || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int    n;
        int    roll;
        id_t   id;
        time_t iv;
        time_t lp;
        time_t t0;
        time_t t1;

        rst_n             = 1'b0;
        req.valid         = 1'b0;
        req.opcode        = 1'b0;
        req.task_id       = '0;
        req.spacing_us    = '0;
        req.loop_start_us = '0;
        req.start_us      = '0;
        req.stop_us       = '0;
        rsp.ready         = 1'b0;
        for (n = 0; n < NUM_TASKS; n++) begin
            tbl_starts[n]  = '0;
            tbl_run_sum[n] = '0;
            tbl_run_lo[n]  = TIME_MAX;
            tbl_run_hi[n]  = '0;
            tbl_per_lo[n]  = TIME_MAX;
            tbl_per_hi[n]  = '0;
            tbl_last[n]    = '0;
            tbl_due[n]     = '0;
            tbl_seen[n]    = 1'b0;
            gen_due[n]     = '0;
            gen_last[n]    = '0;
        end

        // directed: due edges, zero period and run, saturation, clears
        queue_item(OP_PASS, 4'd0, 48'd10, 48'd0, 48'd0, 48'd0);
        queue_item(OP_PASS, 4'd0, 48'd10, 48'd1, 48'd1, 48'd5);
        queue_item(OP_PASS, 4'd0, 48'd10, 48'd11, 48'd11, 48'd12);
        queue_item(OP_PASS, 4'd0, 48'd0, 48'd12, 48'd20, 48'd20);
        queue_item(OP_PASS, 4'd0, 48'd0, 48'd13, 48'd15, 48'd14);
        queue_item(OP_PASS, 4'd0, 48'd3, 48'd14, 48'd30, 48'd100);
        queue_item(OP_PASS, 4'd15, TIME_MAX, TIME_MAX, TIME_MAX, 48'd0);
        queue_item(OP_PASS, 4'd15, 48'd0, TIME_MAX, 48'd0, TIME_MAX);
        queue_item(OP_PASS, 4'd14, 48'h7FFF_FFFF_FFFF, 48'd1, 48'd0, TIME_MAX);
        queue_item(OP_PASS, 4'd14, 48'd0, 48'h8000_0000_0001, 48'h5555_5555_5555,
                   TIME_MAX);
        queue_item(OP_PASS, 4'd14, 48'd1, 48'h8000_0000_0002, 48'hAAAA_AAAA_AAAA,
                   48'hAAAA_AAAA_AAAB);
        queue_item(OP_CLEAR, 4'd14, rand_time(), rand_time(), rand_time(), rand_time());
        queue_item(OP_PASS, 4'd14, 48'd0, 48'h8000_0000_0004, 48'hAAAA_AAAA_AAB0,
                   48'hAAAA_AAAA_AAB7);
        queue_item(OP_PASS, 4'd14, 48'd0, 48'h8000_0000_0005, 48'hAAAA_AAAA_AAC0,
                   48'hAAAA_AAAA_AAC1);
        queue_item(OP_CLEAR, 4'd0, 48'd0, 48'd0, 48'd0, 48'd0);
        queue_item(OP_PASS, 4'd0, 48'd0, 48'd12, 48'd40, 48'd41);
        queue_item(OP_PASS, 4'd3, 48'd5, 48'd1, 48'd5, 48'd2);

        for (n = 0; n < RANDOM_PASSES; n++) begin
            id   = id_t'($urandom_range(0, NUM_TASKS - 1));
            roll = $urandom_range(0, 99);
            iv   = rand_time();
            lp   = rand_time();
            t0   = rand_time();
            t1   = rand_time();
            if (roll < 5) begin
                queue_item(OP_CLEAR, id, iv, lp, t0, t1);
            end
            else if (roll < 12 || gen_due[id] == TIME_MAX) begin
                // not due: loop time at or below next due
                if (gen_due[id] != TIME_MAX)
                    lp = lp % (gen_due[id] + 1'b1);
                queue_item(OP_PASS, id, iv, lp, t0, t1);
            end
            else begin
                if (gen_due[id] == '0)
                    lp = lp >> $urandom_range(1, 20);
                else if ($urandom_range(0, 9) == 0)
                    lp = (gen_due[id] > 48'd3) ?
                         gen_due[id] - time_t'($urandom_range(0, 3)) : gen_due[id];
                else
                    lp = sat_sum(gen_due[id], time_t'($urandom_range(1, 300)));
                roll = $urandom_range(0, 199);
                if (roll >= 10)
                    iv = time_t'($urandom_range(0, 1000));
                else if (roll != 0)
                    iv = (TIME_MAX - lp) >> $urandom_range(2, 12);
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    t0 = (gen_last[id] > 48'd5) ?
                         gen_last[id] - time_t'($urandom_range(0, 5)) : '0;
                else if (roll != 1)
                    t0 = sat_sum(lp, time_t'($urandom_range(0, 100)));
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    t1 = (t0 > 48'd3) ? t0 - time_t'($urandom_range(0, 3)) : t0;
                else if (roll != 1)
                    t1 = sat_sum(t0, time_t'($urandom_range(1, 2000)));
                queue_item(OP_PASS, id, iv, lp, t0, t1);
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (sched_q.size() > 0 || req.valid || stats_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (stats_q.size() > 0) begin
            $display("%0d expected results never arrived", stats_q.size());
            mismatches += stats_q.size();
        end
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
